// File: src/ps2mt_pkg.sv
// shared types and constants for the ps2 mouse packet cursor tracker
// no dependencies
package ps2mt_pkg;

  localparam int unsigned POS_W    = 12;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned BTN_W    = 3;
  localparam int unsigned DX_W     = 9;
  localparam int unsigned DY_W     = 10;
  localparam int unsigned CFG_W    = 12;
  localparam int unsigned CFG_IDX_W = 1;

  localparam int unsigned CURSOR_WIDTH_DEFAULT  = 16;
  localparam int unsigned CURSOR_HEIGHT_DEFAULT = 16;

  localparam logic [BYTE_W-1:0] ACK_BYTE = 8'hFA;
  localparam int unsigned HDR_X_SIGN = 4;
  localparam int unsigned HDR_Y_SIGN = 5;

  localparam logic [CFG_W-1:0] SCREEN_WIDTH_RESET  = 12'd320;
  localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RESET = 12'd200;
  localparam logic [POS_W-1:0] POS_X_RESET         = 12'd160;
  localparam logic [POS_W-1:0] POS_Y_RESET         = 12'd100;

  // register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH  = 1'b0,
    CFG_SCREEN_HEIGHT = 1'b1
  } cfg_reg_t;

  // where the next byte lands within a packet
  typedef enum logic [1:0] {
    POS_HEADER = 2'd0,
    POS_XDATA  = 2'd1,
    POS_YDATA  = 2'd2
  } byte_pos_t;

endpackage

// File: src/ps2mt_axis_clamp.sv
// one axis of the cursor update: add a signed delta, clamp to 0..size-cursor
// depends on ps2mt_pkg
module ps2mt_axis_clamp #(
  parameter int unsigned CURSOR = ps2mt_pkg::CURSOR_WIDTH_DEFAULT
) (
  input  logic [ps2mt_pkg::POS_W-1:0]       pos,
  input  logic signed [ps2mt_pkg::DY_W-1:0] delta,
  input  logic [ps2mt_pkg::POS_W-1:0]       size,
  output logic [ps2mt_pkg::POS_W-1:0]       pos_next
);

  localparam int unsigned SUM_W = ps2mt_pkg::POS_W + 2;
  localparam int unsigned LIM_W = ps2mt_pkg::POS_W + 1;
  localparam logic [LIM_W-1:0] CURSOR_SZ = LIM_W'(CURSOR);

  logic [SUM_W-1:0]            sum;
  logic [LIM_W-1:0]            limit_raw;
  logic [ps2mt_pkg::POS_W-1:0] limit;

  assign sum = {2'b00, pos}
             + {{(SUM_W-ps2mt_pkg::DY_W){delta[ps2mt_pkg::DY_W-1]}}, delta};
  assign limit_raw = {1'b0, size} - CURSOR_SZ;
  // screen smaller than the cursor pins the axis at zero
  assign limit = limit_raw[LIM_W-1] ? '0 : limit_raw[ps2mt_pkg::POS_W-1:0];

  always_comb begin
    if (sum[SUM_W-1] || (sum == '0)) begin
      pos_next = '0;
    end else if (sum[LIM_W-1:0] >= {1'b0, limit}) begin
      pos_next = limit;
    end else begin
      pos_next = sum[ps2mt_pkg::POS_W-1:0];
    end
  end

endmodule

// File: src/ps2_mouse_packet_cursor_tracker.sv
// ps2 mouse three-byte packet decoder with a clamped cursor position
// depends on ps2mt_pkg and ps2mt_axis_clamp
//
//  channel  | signals                                  | transaction
//  ---------+------------------------------------------+---------------------------
//  in       | in_valid, in_ready, mouse_byte           | one raw mouse byte
//  out      | out_valid, out_ready, packet_done ...    | one status word per byte
//  cfg      | cfg_we, cfg_index, cfg_data              | screen width / height write
//
// each byte is handled combinationally: the decode and both axis clamps sit between
// the input and the state/result registers, so a byte is taken every cycle while the
// result is being taken. the result fields are the state registers themselves;
// a stalled result holds in_ready low. reset is synchronous: position 160,100,
// screen 320x200, not synced.
module ps2_mouse_packet_cursor_tracker #(
  parameter int unsigned CURSOR_WIDTH  = ps2mt_pkg::CURSOR_WIDTH_DEFAULT,
  parameter int unsigned CURSOR_HEIGHT = ps2mt_pkg::CURSOR_HEIGHT_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [ps2mt_pkg::BYTE_W-1:0]          mouse_byte,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  packet_done,
  output logic [ps2mt_pkg::BTN_W-1:0]           buttons,
  output logic signed [ps2mt_pkg::DX_W-1:0]     delta_x,
  output logic signed [ps2mt_pkg::DY_W-1:0]     delta_y,
  output logic [ps2mt_pkg::POS_W-1:0]           cursor_x,
  output logic [ps2mt_pkg::POS_W-1:0]           cursor_y,
  output logic                                  synced,
  input  logic                                  cfg_we,
  input  logic [ps2mt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ps2mt_pkg::CFG_W-1:0]           cfg_data
);

  logic [ps2mt_pkg::CFG_W-1:0]       screen_width;
  logic [ps2mt_pkg::CFG_W-1:0]       screen_height;
  logic                              ack_seen;
  ps2mt_pkg::byte_pos_t              byte_position;
  logic [ps2mt_pkg::BYTE_W-1:0]      hdr_byte;
  logic [ps2mt_pkg::BYTE_W-1:0]      x_byte;
  logic [ps2mt_pkg::BTN_W-1:0]       last_buttons;
  logic signed [ps2mt_pkg::DX_W-1:0] last_dx;
  logic signed [ps2mt_pkg::DY_W-1:0] last_dy;
  logic [ps2mt_pkg::POS_W-1:0]       pos_x;
  logic [ps2mt_pkg::POS_W-1:0]       pos_y;
  logic                              done_flag;

  logic                              accept;
  logic                              complete;
  logic signed [ps2mt_pkg::DX_W-1:0] dx_new;
  logic signed [ps2mt_pkg::DX_W-1:0] dy_raw;
  logic signed [ps2mt_pkg::DY_W-1:0] dy_new;
  logic signed [ps2mt_pkg::DY_W-1:0] dx_ext;
  logic [ps2mt_pkg::POS_W-1:0]       pos_x_next;
  logic [ps2mt_pkg::POS_W-1:0]       pos_y_next;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign complete = ack_seen && (byte_position == ps2mt_pkg::POS_YDATA);

  // sign bits of the deltas come from the header
  assign dx_new = {hdr_byte[ps2mt_pkg::HDR_X_SIGN], x_byte};
  assign dy_raw = {hdr_byte[ps2mt_pkg::HDR_Y_SIGN], mouse_byte};
  assign dy_new = -{dy_raw[ps2mt_pkg::DX_W-1], dy_raw};
  assign dx_ext = {dx_new[ps2mt_pkg::DX_W-1], dx_new};

  ps2mt_axis_clamp #(
    .CURSOR (CURSOR_WIDTH)
  ) u_clamp_x (
    .pos      (pos_x),
    .delta    (dx_ext),
    .size     (screen_width),
    .pos_next (pos_x_next)
  );

  ps2mt_axis_clamp #(
    .CURSOR (CURSOR_HEIGHT)
  ) u_clamp_y (
    .pos      (pos_y),
    .delta    (dy_new),
    .size     (screen_height),
    .pos_next (pos_y_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= ps2mt_pkg::SCREEN_WIDTH_RESET;
      screen_height <= ps2mt_pkg::SCREEN_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ps2mt_pkg::CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        ps2mt_pkg::CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      done_flag     <= 1'b0;
      ack_seen      <= 1'b0;
      byte_position <= ps2mt_pkg::POS_HEADER;
      last_buttons  <= '0;
      last_dx       <= '0;
      last_dy       <= '0;
      pos_x         <= ps2mt_pkg::POS_X_RESET;
      pos_y         <= ps2mt_pkg::POS_Y_RESET;
    end else begin
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        done_flag <= complete;
        if (complete) begin
          last_buttons  <= hdr_byte[ps2mt_pkg::BTN_W-1:0];
          last_dx       <= dx_new;
          last_dy       <= dy_new;
          pos_x         <= pos_x_next;
          pos_y         <= pos_y_next;
          byte_position <= ps2mt_pkg::POS_HEADER;
        end else if (ack_seen) begin
          if (byte_position == ps2mt_pkg::POS_HEADER) begin
            byte_position <= ps2mt_pkg::POS_XDATA;
          end else begin
            byte_position <= ps2mt_pkg::POS_YDATA;
          end
        end else if (mouse_byte == ps2mt_pkg::ACK_BYTE) begin
          ack_seen      <= 1'b1;
          byte_position <= ps2mt_pkg::POS_HEADER;
        end
      end
    end
  end

  // packet bytes carry no reset, they are read only after being written
  always_ff @(posedge clk) begin
    if (accept && ack_seen && !complete) begin
      if (byte_position == ps2mt_pkg::POS_HEADER) begin
        hdr_byte <= mouse_byte;
      end else begin
        x_byte <= mouse_byte;
      end
    end
  end

  assign packet_done = done_flag;
  assign buttons     = last_buttons;
  assign delta_x     = last_dx;
  assign delta_y     = last_dy;
  assign cursor_x    = pos_x;
  assign cursor_y    = pos_y;
  assign synced      = ack_seen;

endmodule
